// ===== src/uvs_pkg.sv =====
// Shared types, constants and the coordinate rounding function of the UV sphere vertex generator.
package uvs_pkg;

    localparam int COORD_FRAC_BITS = 14;
    localparam int COORD_SHIFT     = 60 - COORD_FRAC_BITS;

    localparam int LAT_ENTRIES = 33;
    localparam int LON_ENTRIES = 65;
    localparam int LAT_AW      = 6;
    localparam int LON_AW      = 7;
    localparam int MAG_W       = 31;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [16:0] TEX_ONE = 17'd65536;

    localparam logic CFG_SLICE_COUNT = 1'b0;
    localparam logic CFG_RING_COUNT  = 1'b1;

    typedef struct packed {
        logic [4:0] ring_index;
        logic [5:0] slice_index;
    } uvs_in_t;

    typedef struct packed {
        logic [12:0]        vertex_number;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               tri_valid;
        logic [12:0]        tri_first;
        logic [12:0]        tri_second;
        logic [12:0]        tri_third;
        logic               out_of_range;
        logic               last_corner;
    } uvs_out_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } smag_t;

    typedef struct packed {
        smag_t       sn;
        smag_t       cs;
        logic [16:0] tex;
    } tbl_entry_t;

    typedef struct packed {
        logic              we;
        logic              is_lon;
        logic [LON_AW-1:0] addr;
        tbl_entry_t        data;
    } tbl_wr_t;

    typedef struct packed {
        logic [6:0] slices;
        logic [5:0] rings;
    } counts_t;

    typedef struct packed {
        logic [4:0]  ring_index;
        logic [5:0]  slice_index;
        logic [12:0] base;
        logic        oor;
    } quad_t;

    function automatic logic [15:0] coord_round(input logic [61:0] mag60, input logic neg);
        logic [61:0] r;
        r = (mag60 + (62'd1 << (COORD_SHIFT - 1))) >> COORD_SHIFT;
        coord_round = neg ? 16'(~r[15:0] + 16'd1) : r[15:0];
    endfunction

endpackage

// ===== src/uvs_front.sv =====
// Front end: configuration registers, quad acceptance and classification.
module uvs_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  uvs_pkg::uvs_in_t                s_data,
    input  logic                            tbl_ready,
    input  logic                            q_ready,
    output logic                            q_push,
    output uvs_pkg::quad_t                  q_data,
    output uvs_pkg::counts_t                counts,
    output logic                            cfg_written
);
    import uvs_pkg::*;

    logic [6:0]  slice_count_reg;
    logic [5:0]  ring_count_reg;
    logic [11:0] lin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg <= 7'd32;
            ring_count_reg  <= 6'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SLICE_COUNT: slice_count_reg <= cfg_wdata;
                CFG_RING_COUNT:  ring_count_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    assign counts.slices = (slice_count_reg == 7'd0) ? 7'd1 : slice_count_reg;
    assign counts.rings  = (ring_count_reg == 6'd0) ? 6'd1 : ring_count_reg;
    assign cfg_written   = cfg_wr_en;

    assign lin = 12'(s_data.ring_index) * 12'(counts.slices) + 12'(s_data.slice_index);

    assign q_data.ring_index  = s_data.ring_index;
    assign q_data.slice_index = s_data.slice_index;
    assign q_data.base        = {lin[10:0], 2'b00};
    assign q_data.oor         = ({1'b0, s_data.ring_index} >= ring_count_reg)
                              || ({1'b0, s_data.slice_index} >= slice_count_reg);

    assign s_ready = tbl_ready && q_ready;
    assign q_push  = s_valid && s_ready;

endmodule

// ===== src/uvs_queue.sv =====
// Short queue of classified quads between the front and back ends.
module uvs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  uvs_pkg::quad_t  push_data,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output uvs_pkg::quad_t  pop_data
);
    import uvs_pkg::*;

    quad_t                 slot_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;

    assign push_ready = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_q[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_q[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/uvs_table_build.sv =====
// Table builder: sequential phase, sine/cosine series and texture evaluation per grid line.
module uvs_table_build (
    input  logic              aclk,
    input  logic              aresetn,
    input  uvs_pkg::counts_t  counts,
    input  logic              cfg_written,
    output logic              tbl_ready,
    output uvs_pkg::tbl_wr_t  tbl_wr
);
    import uvs_pkg::*;

    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic [30:0] HALF_PI    = 31'd1686629713;
    localparam logic [6:0]  LAT_LAST   = 7'(LAT_ENTRIES - 1);
    localparam logic [6:0]  LON_LAST   = 7'(LON_ENTRIES - 1);
    localparam logic [5:0]  DIV_STEPS  = 6'd40;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_NEXT  = 14'b00000000000010,
        S_DIV   = 14'b00000000000100,
        S_FOLD  = 14'b00000000001000,
        S_MX    = 14'b00000000010000,
        S_MX2   = 14'b00000000100000,
        S_X2    = 14'b00000001000000,
        S_TMUL  = 14'b00000010000000,
        S_TLD   = 14'b00000100000000,
        S_TQ    = 14'b00001000000000,
        S_TSTEP = 14'b00010000000000,
        S_SMUL  = 14'b00100000000000,
        S_SGET  = 14'b01000000000000,
        S_WRITE = 14'b10000000000000
    } state_t;

    state_t      state_reg, ret_reg;
    logic        pending_reg;
    logic        is_lon_reg;
    logic [6:0]  idx_reg;
    logic [2:0]  k_reg;
    logic        cos_reg;
    logic [1:0]  quad_reg;
    logic        swap_reg;
    logic [29:0] r_reg;
    logic [29:0] x_reg;
    logic [29:0] x2_reg;
    logic [30:0] t_reg;
    logic [30:0] s_reg;
    logic [29:0] a_reg;
    logic [29:0] q_reg;
    smag_t       sn_reg, cs_reg;
    logic [61:0] prod_reg;
    logic [30:0] mul_a, mul_b;

    logic [39:0] dvd_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  dsr_reg;
    logic [5:0]  dcnt_reg;
    logic        div_load;
    logic [39:0] div_dvd_in;
    logic [7:0]  div_dsr_in;
    logic [8:0]  trial;
    logic        trial_ge;
    logic        div_done;

    logic [7:0]  step_d;
    logic [30:0] step_m;
    logic [30:0] rem_est;
    logic [29:0] quo;

    logic [7:0]  n_trig, n_tex;
    logic [39:0] phase_dvd, tex_dvd;
    logic [29:0] r_raw;
    logic [30:0] bs, bc;
    logic [23:0] tex_quo;
    logic [16:0] tex_val;
    logic        fin_step;

    assign n_trig    = is_lon_reg ? {1'b0, counts.slices} : {1'b0, counts.rings, 1'b0};
    assign n_tex     = is_lon_reg ? {1'b0, counts.slices} : {2'b00, counts.rings};
    assign phase_dvd = {1'b0, idx_reg, 32'd0} + 40'(n_trig >> 1);
    assign tex_dvd   = 40'({idx_reg, 16'd0}) + 40'(n_tex >> 1);

    assign trial    = {rem_reg, dvd_reg[39]};
    assign trial_ge = trial >= {1'b0, dsr_reg};
    assign div_done = dcnt_reg == 6'd0;

    assign r_raw = dvd_reg[29:0];
    assign bs    = swap_reg ? t_reg : s_reg;
    assign bc    = swap_reg ? s_reg : t_reg;

    always_comb begin
        unique case ({cos_reg, k_reg})
            4'b0_000: begin step_d = 8'd156; step_m = 31'd13765920;   end
            4'b0_001: begin step_d = 8'd110; step_m = 31'd19522578;   end
            4'b0_010: begin step_d = 8'd72;  step_m = 31'd29826161;   end
            4'b0_011: begin step_d = 8'd42;  step_m = 31'd51130563;   end
            4'b0_100: begin step_d = 8'd20;  step_m = 31'd107374182;  end
            4'b0_101: begin step_d = 8'd6;   step_m = 31'd357913941;  end
            4'b1_000: begin step_d = 8'd182; step_m = 31'd11799360;   end
            4'b1_001: begin step_d = 8'd132; step_m = 31'd16268815;   end
            4'b1_010: begin step_d = 8'd90;  step_m = 31'd23860929;   end
            4'b1_011: begin step_d = 8'd56;  step_m = 31'd38347922;   end
            4'b1_100: begin step_d = 8'd30;  step_m = 31'd71582788;   end
            4'b1_101: begin step_d = 8'd12;  step_m = 31'd178956970;  end
            4'b1_110: begin step_d = 8'd2;   step_m = 31'd1073741824; end
            default:  begin step_d = '0;     step_m = '0;             end
        endcase
    end

    assign rem_est = {1'b0, a_reg} - prod_reg[30:0];
    assign quo     = q_reg + {29'd0, (rem_est >= {23'd0, step_d})};

    assign tex_quo = dvd_reg[23:0];
    always_comb begin
        if (is_lon_reg) begin
            tex_val = (tex_quo > 24'd65536) ? TEX_ONE : tex_quo[16:0];
        end else begin
            tex_val = (tex_quo >= 24'd65536) ? 17'd0 : 17'(TEX_ONE - tex_quo[16:0]);
        end
    end

    assign fin_step = cos_reg ? (k_reg == 3'd6) : (k_reg == 3'd5);

    always_comb begin
        mul_a      = '0;
        mul_b      = '0;
        div_load   = 1'b0;
        div_dvd_in = phase_dvd;
        div_dsr_in = n_trig;
        unique case (state_reg)
            S_NEXT: begin
                div_load = 1'b1;
            end
            S_MX: begin
                mul_a = {1'b0, r_reg};
                mul_b = HALF_PI;
            end
            S_MX2: begin
                mul_a = {1'b0, prod_reg[59:30]};
                mul_b = {1'b0, prod_reg[59:30]};
            end
            S_TMUL: begin
                mul_a = {1'b0, x2_reg};
                mul_b = t_reg;
            end
            S_TLD: begin
                mul_a = {1'b0, prod_reg[59:30]};
                mul_b = step_m;
            end
            S_TQ: begin
                mul_a = {1'b0, prod_reg[60:31]};
                mul_b = {23'd0, step_d};
            end
            S_SMUL: begin
                mul_a = {1'b0, x_reg};
                mul_b = t_reg;
            end
            S_TSTEP: begin
                if (cos_reg && fin_step) begin
                    div_load   = 1'b1;
                    div_dvd_in = tex_dvd;
                    div_dsr_in = n_tex;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (div_load) begin
            dvd_reg <= div_dvd_in;
            rem_reg <= '0;
            dsr_reg <= div_dsr_in;
        end else if (!div_done) begin
            dvd_reg <= {dvd_reg[38:0], trial_ge};
            rem_reg <= trial_ge ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            pending_reg <= 1'b1;
            dcnt_reg    <= '0;
            is_lon_reg  <= 1'b0;
            idx_reg     <= '0;
            k_reg       <= '0;
            cos_reg     <= 1'b0;
        end else begin
            if (div_load) begin
                dcnt_reg <= DIV_STEPS;
            end else if (!div_done) begin
                dcnt_reg <= dcnt_reg - 6'd1;
            end
            if (cfg_written) begin
                state_reg   <= S_IDLE;
                pending_reg <= 1'b1;
            end else begin
                unique case (state_reg)
                    S_IDLE: begin
                        if (pending_reg) begin
                            pending_reg <= 1'b0;
                            is_lon_reg  <= 1'b0;
                            idx_reg     <= '0;
                            state_reg   <= S_NEXT;
                        end
                    end
                    S_NEXT: begin
                        ret_reg   <= S_FOLD;
                        state_reg <= S_DIV;
                    end
                    S_DIV: begin
                        if (div_done) begin
                            state_reg <= ret_reg;
                        end
                    end
                    S_FOLD: begin
                        quad_reg <= dvd_reg[31:30];
                        if (r_raw > 30'h2000_0000) begin
                            r_reg    <= 30'(31'h4000_0000 - {1'b0, r_raw});
                            swap_reg <= 1'b1;
                        end else begin
                            r_reg    <= r_raw;
                            swap_reg <= 1'b0;
                        end
                        state_reg <= S_MX;
                    end
                    S_MX: begin
                        state_reg <= S_MX2;
                    end
                    S_MX2: begin
                        x_reg     <= prod_reg[59:30];
                        state_reg <= S_X2;
                    end
                    S_X2: begin
                        x2_reg    <= prod_reg[59:30];
                        t_reg     <= Q30_ONE;
                        k_reg     <= '0;
                        cos_reg   <= 1'b0;
                        state_reg <= S_TMUL;
                    end
                    S_TMUL: begin
                        state_reg <= S_TLD;
                    end
                    S_TLD: begin
                        a_reg     <= prod_reg[59:30];
                        state_reg <= S_TQ;
                    end
                    S_TQ: begin
                        q_reg     <= prod_reg[60:31];
                        state_reg <= S_TSTEP;
                    end
                    S_TSTEP: begin
                        t_reg <= Q30_ONE - {1'b0, quo};
                        if (fin_step && !cos_reg) begin
                            state_reg <= S_SMUL;
                        end else if (fin_step) begin
                            ret_reg   <= S_WRITE;
                            state_reg <= S_DIV;
                        end else begin
                            k_reg     <= k_reg + 3'd1;
                            state_reg <= S_TMUL;
                        end
                    end
                    S_SMUL: begin
                        state_reg <= S_SGET;
                    end
                    S_SGET: begin
                        s_reg     <= prod_reg[60:30];
                        t_reg     <= Q30_ONE;
                        k_reg     <= '0;
                        cos_reg   <= 1'b1;
                        state_reg <= S_TMUL;
                    end
                    S_WRITE: begin
                        if (!is_lon_reg && idx_reg == LAT_LAST) begin
                            is_lon_reg <= 1'b1;
                            idx_reg    <= '0;
                            state_reg  <= S_NEXT;
                        end else if (is_lon_reg && idx_reg == LON_LAST) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 7'd1;
                            state_reg <= S_NEXT;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        unique case (quad_reg)
            2'd0: begin
                sn_reg = '{neg: 1'b0, mag: bs};
                cs_reg = '{neg: 1'b0, mag: bc};
            end
            2'd1: begin
                sn_reg = '{neg: 1'b0, mag: bc};
                cs_reg = '{neg: 1'b1, mag: bs};
            end
            2'd2: begin
                sn_reg = '{neg: 1'b1, mag: bs};
                cs_reg = '{neg: 1'b1, mag: bc};
            end
            default: begin
                sn_reg = '{neg: 1'b1, mag: bc};
                cs_reg = '{neg: 1'b0, mag: bs};
            end
        endcase
    end

    assign tbl_ready       = (state_reg == S_IDLE) && !pending_reg;
    assign tbl_wr.we       = (state_reg == S_WRITE) && !cfg_written;
    assign tbl_wr.is_lon   = is_lon_reg;
    assign tbl_wr.addr     = idx_reg;
    assign tbl_wr.data.sn  = sn_reg;
    assign tbl_wr.data.cs  = cs_reg;
    assign tbl_wr.data.tex = tex_val;

endmodule

// ===== src/uvs_back.sv =====
// Back end: corner sequencing, table reads, position products and result register.
module uvs_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  uvs_pkg::quad_t    q_data,
    output logic              q_pop,
    input  uvs_pkg::tbl_wr_t  tbl_wr,
    output logic              m_valid,
    input  logic              m_ready,
    output uvs_pkg::uvs_out_t m_data
);
    import uvs_pkg::*;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    typedef struct packed {
        logic [12:0] vnum;
        logic        tri_valid;
        logic [12:0] tri_first;
        logic [12:0] tri_second;
        logic [12:0] tri_third;
        logic        oor;
        logic        last;
    } side_t;

    tbl_entry_t lat_mem [LAT_ENTRIES];
    tbl_entry_t lon_mem [LON_ENTRIES];

    logic              adv;
    logic [1:0]        corner_reg;
    logic [LAT_AW-1:0] ic;
    logic [LON_AW-1:0] jc;
    logic [12:0]       b;
    side_t             side0, side1_reg, side2_reg;
    logic              v1_reg, v2_reg;
    tbl_entry_t        lat_rd_reg, lon_rd_reg;
    logic [61:0]       px_reg, pz_reg;
    logic              px_neg_reg, pz_neg_reg;
    smag_t             cy_reg;
    logic [16:0]       u_reg, v_reg;
    logic              m_valid_reg;
    uvs_out_t          m_data_reg;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid && (corner_reg == CORNER_LAST);
    assign ic    = {1'b0, q_data.ring_index} + LAT_AW'(corner_reg[0]);
    assign jc    = {1'b0, q_data.slice_index} + LON_AW'(corner_reg[1]);
    assign b     = q_data.base;

    always_comb begin
        side0.vnum = b + 13'(corner_reg);
        side0.oor  = q_data.oor;
        side0.last = corner_reg == CORNER_LAST;
        case (corner_reg)
            2'd0: begin
                side0.tri_valid  = 1'b1;
                side0.tri_first  = b;
                side0.tri_second = b + 13'd1;
                side0.tri_third  = b + 13'd2;
            end
            2'd1: begin
                side0.tri_valid  = 1'b1;
                side0.tri_first  = b + 13'd1;
                side0.tri_second = b + 13'd3;
                side0.tri_third  = b + 13'd2;
            end
            default: begin
                side0.tri_valid  = 1'b0;
                side0.tri_first  = '0;
                side0.tri_second = '0;
                side0.tri_third  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr.we && !tbl_wr.is_lon) begin
            lat_mem[tbl_wr.addr[LAT_AW-1:0]] <= tbl_wr.data;
        end
        if (adv) begin
            lat_rd_reg <= lat_mem[ic];
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr.we && tbl_wr.is_lon) begin
            lon_mem[tbl_wr.addr] <= tbl_wr.data;
        end
        if (adv) begin
            lon_rd_reg <= lon_mem[jc];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg  <= side0;
            side2_reg  <= side1_reg;
            px_reg     <= lat_rd_reg.sn.mag * lon_rd_reg.cs.mag;
            pz_reg     <= lat_rd_reg.sn.mag * lon_rd_reg.sn.mag;
            px_neg_reg <= lat_rd_reg.sn.neg ^ lon_rd_reg.cs.neg;
            pz_neg_reg <= lat_rd_reg.sn.neg ^ lon_rd_reg.sn.neg;
            cy_reg     <= lat_rd_reg.cs;
            u_reg      <= lon_rd_reg.tex;
            v_reg      <= lat_rd_reg.tex;

            m_data_reg.vertex_number <= side2_reg.vnum;
            m_data_reg.pos_x         <= coord_round(px_reg, px_neg_reg);
            m_data_reg.pos_y         <= coord_round(62'({cy_reg.mag, 30'd0}), !cy_reg.neg);
            m_data_reg.pos_z         <= coord_round(pz_reg, pz_neg_reg);
            m_data_reg.tex_u         <= u_reg;
            m_data_reg.tex_v         <= v_reg;
            m_data_reg.tri_valid     <= side2_reg.tri_valid;
            m_data_reg.tri_first     <= side2_reg.tri_first;
            m_data_reg.tri_second    <= side2_reg.tri_second;
            m_data_reg.tri_third     <= side2_reg.tri_third;
            m_data_reg.out_of_range  <= side2_reg.oor;
            m_data_reg.last_corner   <= side2_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_reg  <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= q_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
            if (q_valid) begin
                corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && adv && corner_reg != CORNER_LAST) |=> q_valid)
        else $error("quad left the queue before its last corner");

    a_pipe_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v1_reg) |=> v2_reg)
        else $error("corner lost between product stages");

    a_tri_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.tri_valid) |-> !m_data.last_corner)
        else $error("triangle carried on the final corner");

endmodule

// ===== src/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator: one quad in, four corner results out.
//
//   channel   ports                         transaction
//   config    cfg_wr_en, cfg_index, wdata   write slice_count (0) or ring_count (1)
//   input     s_valid, s_ready, s_data      one quad: ring and slice index
//   result    m_valid, m_ready, m_data      one corner, four per quad
//
// One corner per cycle while the result side does not stall; a new quad enters while the previous
// one's corners are still in the three-stage back end (table read, product, round).
// After reset and after every register write the grid tables are rebuilt by a shared
// serial divider and multiplier, 98 entries in all; s_ready stays low during the rebuild.
// Result stalls hold the back end; the two-entry quad queue lets the front take quads until it is full.
module uv_sphere_vertex_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  uvs_pkg::uvs_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output uvs_pkg::uvs_out_t               m_data
);
    import uvs_pkg::*;

    logic     tbl_ready;
    tbl_wr_t  tbl_wr;
    counts_t  counts;
    logic     cfg_written;
    logic     q_push, q_ready, q_pop, q_valid;
    quad_t    q_in, q_out;

    uvs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .tbl_ready   (tbl_ready),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_data      (q_in),
        .counts      (counts),
        .cfg_written (cfg_written)
    );

    uvs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out)
    );

    uvs_table_build u_build (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .counts      (counts),
        .cfg_written (cfg_written),
        .tbl_ready   (tbl_ready),
        .tbl_wr      (tbl_wr)
    );

    uvs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .tbl_wr  (tbl_wr),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of uv_sphere_vertex_generator: quads in, four predicted corners out.
`timescale 1ns / 100ps

module tb;
    import uvs_pkg::*;

    localparam longint unsigned Q30_ONE   = 64'd1073741824;
    localparam longint unsigned HALF_PI   = 64'd1686629713;
    localparam longint unsigned TEX_SCALE = 64'd65536;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = CFG_SLICE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    uvs_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    uvs_out_t              m_data;

    uvs_in_t  pending_quads[$];
    uvs_out_t corner_q[$];
    int       mismatches = 0;
    int       send_gap = 0;
    int       recv_gap = 0;
    bit       quiet = 1'b0;
    int       slices_cfg = 32;
    int       rings_cfg = 16;

    uv_sphere_vertex_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic int draw_gap();
        int r;
        if ($urandom_range(0, 47) == 0) quiet = !quiet;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] turn_phase(input int k, input int n);
        longint unsigned num;
        num = (longint'(k) << 32) + longint'(n / 2);
        return 32'(num / longint'(n));
    endfunction

    function automatic void sin_cos(input logic [31:0] ph,
                                    output logic sn_neg, output longint unsigned sn_mag,
                                    output logic cs_neg, output longint unsigned cs_mag);
        longint unsigned sdiv[6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cdiv[7] = '{182, 132, 90, 56, 30, 12, 2};
        longint unsigned r, x, x2, t, s, c, bs, bc;
        bit swap;
        r = longint'(ph[29:0]);
        swap = 1'b0;
        if (r > (Q30_ONE >> 1)) begin
            r = Q30_ONE - r;
            swap = 1'b1;
        end
        x = (r * HALF_PI) >> 30;
        x2 = (x * x) >> 30;
        t = Q30_ONE;
        for (int k = 0; k < 6; k++) t = Q30_ONE - ((x2 * t) >> 30) / sdiv[k];
        s = (x * t) >> 30;
        t = Q30_ONE;
        for (int k = 0; k < 7; k++) t = Q30_ONE - ((x2 * t) >> 30) / cdiv[k];
        c = t;
        bs = swap ? c : s;
        bc = swap ? s : c;
        case (ph[31:30])
            2'd0: begin sn_mag = bs; sn_neg = 0; cs_mag = bc; cs_neg = 0; end
            2'd1: begin sn_mag = bc; sn_neg = 0; cs_mag = bs; cs_neg = 1; end
            2'd2: begin sn_mag = bs; sn_neg = 1; cs_mag = bc; cs_neg = 1; end
            default: begin sn_mag = bc; sn_neg = 1; cs_mag = bs; cs_neg = 0; end
        endcase
    endfunction

    function automatic logic [15:0] q60_to_coord(input longint unsigned mag, input logic neg);
        longint unsigned r;
        r = (mag + (64'd1 << (COORD_SHIFT - 1))) >> COORD_SHIFT;
        return neg ? 16'(-r) : 16'(r);
    endfunction

    function automatic void predict_corners(input uvs_in_t quad);
        int ns, nr, ic, jc;
        logic [12:0] base;
        logic oor, sa_n, ca_n, sl_n, cl_n;
        longint unsigned sa, ca, sl, cl, u, vq;
        uvs_out_t o;
        ns = (slices_cfg == 0) ? 1 : slices_cfg;
        nr = (rings_cfg == 0) ? 1 : rings_cfg;
        oor = (int'(quad.ring_index) >= rings_cfg) || (int'(quad.slice_index) >= slices_cfg);
        base = 13'(4 * (int'(quad.ring_index) * ns + int'(quad.slice_index)));
        for (int c = 0; c < 4; c++) begin
            ic = int'(quad.ring_index) + (c & 1);
            jc = int'(quad.slice_index) + (c >> 1);
            sin_cos(turn_phase(ic, 2 * nr), sa_n, sa, ca_n, ca);
            sin_cos(turn_phase(jc, ns), sl_n, sl, cl_n, cl);
            o = '0;
            o.vertex_number = base + 13'(c);
            o.pos_x = q60_to_coord(sa * cl, sa_n != cl_n);
            o.pos_y = q60_to_coord(ca << 30, !ca_n);
            o.pos_z = q60_to_coord(sa * sl, sa_n != sl_n);
            u = (longint'(jc) * TEX_SCALE + longint'(ns / 2)) / longint'(ns);
            o.tex_u = (u > TEX_SCALE) ? TEX_ONE : 17'(u);
            vq = (longint'(ic) * TEX_SCALE + longint'(nr / 2)) / longint'(nr);
            o.tex_v = (vq >= TEX_SCALE) ? 17'd0 : 17'(TEX_SCALE - vq);
            if (c == 0) begin
                o.tri_valid = 1'b1;
                o.tri_first = base;
                o.tri_second = base + 13'd1;
                o.tri_third = base + 13'd2;
            end else if (c == 1) begin
                o.tri_valid = 1'b1;
                o.tri_first = base + 13'd1;
                o.tri_second = base + 13'd3;
                o.tri_third = base + 13'd2;
            end
            o.out_of_range = oor;
            o.last_corner = (c == 3);
            corner_q.push_back(o);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_quads.size() > 0) begin
                s_data <= pending_quads.pop_front();
                s_valid <= 1'b1;
                send_gap <= draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (m_valid && m_ready) recv_gap <= draw_gap();
        end
    end

    always @(posedge aclk) begin
        uvs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (corner_q.size() == 0) begin
                $error("unexpected corner transaction");
                mismatches++;
            end else begin
                want = corner_q.pop_front();
                if (m_data.vertex_number !== want.vertex_number) begin
                    $error("vertex_number exp %0d got %0d", want.vertex_number, m_data.vertex_number);
                    mismatches++;
                end
                if (m_data.pos_x !== want.pos_x) begin
                    $error("pos_x exp %0d got %0d", want.pos_x, m_data.pos_x);
                    mismatches++;
                end
                if (m_data.pos_y !== want.pos_y) begin
                    $error("pos_y exp %0d got %0d", want.pos_y, m_data.pos_y);
                    mismatches++;
                end
                if (m_data.pos_z !== want.pos_z) begin
                    $error("pos_z exp %0d got %0d", want.pos_z, m_data.pos_z);
                    mismatches++;
                end
                if (m_data.tex_u !== want.tex_u) begin
                    $error("tex_u exp %0d got %0d", want.tex_u, m_data.tex_u);
                    mismatches++;
                end
                if (m_data.tex_v !== want.tex_v) begin
                    $error("tex_v exp %0d got %0d", want.tex_v, m_data.tex_v);
                    mismatches++;
                end
                if (m_data.tri_valid !== want.tri_valid) begin
                    $error("tri_valid exp %0d got %0d", want.tri_valid, m_data.tri_valid);
                    mismatches++;
                end
                if (m_data.tri_first !== want.tri_first) begin
                    $error("tri_first exp %0d got %0d", want.tri_first, m_data.tri_first);
                    mismatches++;
                end
                if (m_data.tri_second !== want.tri_second) begin
                    $error("tri_second exp %0d got %0d", want.tri_second, m_data.tri_second);
                    mismatches++;
                end
                if (m_data.tri_third !== want.tri_third) begin
                    $error("tri_third exp %0d got %0d", want.tri_third, m_data.tri_third);
                    mismatches++;
                end
                if (m_data.out_of_range !== want.out_of_range) begin
                    $error("out_of_range exp %0d got %0d", want.out_of_range, m_data.out_of_range);
                    mismatches++;
                end
                if (m_data.last_corner !== want.last_corner) begin
                    $error("last_corner exp %0d got %0d", want.last_corner, m_data.last_corner);
                    mismatches++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) predict_corners(s_data);
    end

    task automatic write_reg(input logic idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        if (idx == CFG_SLICE_COUNT) slices_cfg = value;
        else rings_cfg = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_quad(input int ring, input int slice);
        uvs_in_t q;
        q.ring_index = 5'(ring);
        q.slice_index = 6'(slice);
        pending_quads.push_back(q);
    endtask

    task automatic drain();
        while (pending_quads.size() != 0 || s_valid || corner_q.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_quads(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) != 0)
                push_quad($urandom_range(0, (rings_cfg > 32 ? 32 : rings_cfg) - 1),
                          $urandom_range(0, (slices_cfg > 64 ? 64 : slices_cfg) - 1));
            else
                push_quad($urandom_range(0, 31), $urandom_range(0, 63));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        push_quad(0, 0);
        push_quad(15, 31);
        push_quad(16, 0);
        push_quad(0, 32);
        push_quad(31, 63);
        push_quad(21, 42);
        push_quad(10, 21);
        push_quad(7, 16);
        random_quads(16);
        drain();

        write_reg(CFG_SLICE_COUNT, 64);
        write_reg(CFG_RING_COUNT, 32);
        push_quad(31, 63);
        push_quad(0, 63);
        push_quad(31, 0);
        push_quad(16, 32);
        random_quads(20);
        drain();

        write_reg(CFG_SLICE_COUNT, 1);
        write_reg(CFG_RING_COUNT, 1);
        push_quad(0, 0);
        push_quad(1, 0);
        push_quad(0, 1);
        random_quads(20);
        drain();

        write_reg(CFG_SLICE_COUNT, 3);
        write_reg(CFG_RING_COUNT, 2);
        push_quad(1, 2);
        push_quad(2, 3);
        random_quads(20);
        drain();

        write_reg(CFG_SLICE_COUNT, 37);
        write_reg(CFG_RING_COUNT, 5);
        push_quad(4, 36);
        push_quad(5, 37);
        random_quads(24);
        drain();

        if (mismatches == 0)
            $display("uv_sphere_vertex_generator: match");
        else
            $display("uv_sphere_vertex_generator: mismatch");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("uv_sphere_vertex_generator: mismatch");
        $finish;
    end

endmodule
